FILE: src/bss_pkg.sv
// Shared types and constants for the block stripe segmenter.
// No dependencies; imported by every module under src.
package bss_pkg;

  localparam int unsigned LocW        = 40;
  localparam int unsigned LenW        = 32;
  localparam int unsigned BsW         = 17;  // block size, 1..65536
  localparam int unsigned NcW         = 7;   // node count, 1..64
  localparam int unsigned NodeW       = 6;   // owner node index
  localparam int unsigned DvsW        = 23;  // block size * node count, up to 2^22
  localparam int unsigned StepW       = 6;   // divider step counter
  localparam int unsigned MaxSegments = 64;
  localparam int unsigned SegLimW     = BsW + 7;  // block size * MaxSegments
  localparam int unsigned SplitW      = 20;  // split point of the row * block size product
  localparam int unsigned PaddrW      = 3;

  localparam logic [BsW-1:0]   BsMax      = 17'd65536;
  localparam logic [BsW-1:0]   BsReset    = 17'd8192;
  localparam logic [NcW-1:0]   NcMax      = 7'd64;
  localparam logic [NcW-1:0]   NcReset    = 7'd1;
  localparam logic [StepW-1:0] StepsLoc   = 6'd40;
  localparam logic [StepW-1:0] StepsNode  = 6'd6;

  // register index, taken from paddr[2]
  localparam logic RegBlockSize = 1'b0;
  localparam logic RegNodeCount = 1'b1;

  typedef struct packed {
    logic [LocW-1:0] location;
    logic [LenW-1:0] length;
  } in_item_t;

  typedef struct packed {
    logic [NodeW-1:0] owner_node;
    logic [LocW-1:0]  local_address;
    logic [BsW-1:0]   segment_size;
    logic [LenW-1:0]  request_offset;
    logic             last;
    logic             too_many_blocks;
  } out_item_t;

  typedef struct packed {
    logic [BsW-1:0] block_size;  // effective, clamped
    logic [NcW-1:0] node_count;  // effective, clamped
  } cfg_t;

  typedef struct packed {
    logic [DvsW-1:0]  rem_init;
    logic [LocW-1:0]  dividend;  // consumed MSB first
    logic [DvsW-1:0]  divisor;
    logic [StepW-1:0] steps;
  } div_req_t;

  typedef struct packed {
    logic            done;
    logic [LocW-1:0] quotient;
    logic [DvsW-1:0] remainder;
  } div_rsp_t;

  typedef enum logic [3:0] {
    StIdle,
    StProduct,
    StDivLoc,
    StWaitLoc,
    StDivNode,
    StWaitNode,
    StMulHi,
    StMulLo,
    StBase,
    StEmit,
    StError
  } state_e;

endpackage

FILE: src/bss_cfg.sv
// APB register file: block size and node count, with clamped copies.
// Depends on bss_pkg.
module bss_cfg (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [bss_pkg::PaddrW-1:0] paddr,
  input  logic [31:0]               pwdata,
  output logic [31:0]               prdata,
  output logic                      pready,
  output bss_pkg::cfg_t             cfg_o
);
  import bss_pkg::*;

  logic [BsW-1:0] block_size_q;
  logic [NcW-1:0] node_count_q;
  logic           wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      block_size_q <= BsReset;
      node_count_q <= NcReset;
    end else if (wr_en) begin
      case (paddr[2])
        RegBlockSize: block_size_q <= pwdata[BsW-1:0];
        RegNodeCount: node_count_q <= pwdata[NcW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      RegBlockSize: prdata = {{(32-BsW){1'b0}}, block_size_q};
      RegNodeCount: prdata = {{(32-NcW){1'b0}}, node_count_q};
      default:      prdata = '0;
    endcase
  end

  // zero reads as one, oversize as the maximum
  always_comb begin
    if (block_size_q == '0)       cfg_o.block_size = BsW'(1);
    else if (block_size_q > BsMax) cfg_o.block_size = BsMax;
    else                          cfg_o.block_size = block_size_q;

    if (node_count_q == '0)       cfg_o.node_count = NcW'(1);
    else if (node_count_q > NcMax) cfg_o.node_count = NcMax;
    else                          cfg_o.node_count = node_count_q;
  end

endmodule

FILE: src/bss_div.sv
// Shared restoring divider, one quotient bit per cycle.
// Depends on bss_pkg.
module bss_div (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  bss_pkg::div_req_t   req_i,
  output bss_pkg::div_rsp_t   rsp_o
);
  import bss_pkg::*;

  logic             busy_q;
  logic             done_q;
  logic [StepW-1:0] cnt_q;
  logic [DvsW-1:0]  rem_q;
  logic [LocW-1:0]  quo_q;
  logic [DvsW-1:0]  dvs_q;
  logic [DvsW:0]    trial;

  assign trial = {rem_q, quo_q[LocW-1]} - {1'b0, dvs_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= busy_q && (cnt_q == StepW'(1));
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= req_i.steps;
      end else if (busy_q) begin
        cnt_q <= cnt_q - StepW'(1);
        if (cnt_q == StepW'(1)) busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= req_i.rem_init;
      quo_q <= req_i.dividend;
      dvs_q <= req_i.divisor;
    end else if (busy_q) begin
      if (!trial[DvsW]) begin
        rem_q <= trial[DvsW-1:0];
        quo_q <= {quo_q[LocW-2:0], 1'b1};
      end else begin
        rem_q <= {rem_q[DvsW-2:0], quo_q[LocW-1]};
        quo_q <= {quo_q[LocW-2:0], 1'b0};
      end
    end
  end

  assign rsp_o.done      = done_q;
  assign rsp_o.quotient  = quo_q;
  assign rsp_o.remainder = rem_q;

endmodule

FILE: src/block_stripe_segmenter_top.sv
// Top level of the block stripe segmenter: request sequencer and output stage.
// Depends on bss_pkg, bss_cfg and bss_div.
//
// Usage:
//   A request (location, length) enters on the in channel (valid/ready).
//   The block splits it into one segment per stripe block touched and
//   sends them in block order on the out channel, the final one with last.
//   A zero length gives no output; a request over MaxSegments blocks gives
//   one transaction with too_many_blocks and last set, all else zero.
//   Block size and node count sit behind the APB port (0x0 and 0x4) and
//   are for the user to write only while the block is idle; it does not check.
// Timing:
//   One shared divider does two passes: location / (block size * node
//   count), then the remainder / block size. After the product, the two
//   passes, the high and low partial products and the base add, the first
//   segment is registered; further segments follow one per cycle while
//   out_ready_i is high, and in_ready_o is high only between requests.
// Reset and stalls:
//   Reset returns the sequencer to idle, drops any pending output and
//   loads the register defaults (block size 8192, one node). When out_ready_i
//   is low the output register holds its transaction and emission pauses.
module block_stripe_segmenter_top (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  bss_pkg::in_item_t          in_data_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output bss_pkg::out_item_t         out_data_o,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [bss_pkg::PaddrW-1:0] paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready
);
  import bss_pkg::*;

  cfg_t     cfg;
  div_req_t div_req;
  div_rsp_t div_rsp;
  logic     div_start;

  state_e state_q, state_d;

  // request and walk registers
  logic [LocW-1:0]   loc_q;
  logic [LenW-1:0]   len_q;
  logic [DvsW-1:0]   bsnc_q;    // block size * node count
  logic [LocW-1:0]   row_q;     // first block / node count
  logic [DvsW-1:0]   r1_q;      // location mod (block size * node count)
  logic [NodeW-1:0]  node_q;
  logic [BsW-1:0]    off_q;
  logic [SplitW-1:0] ph_q;
  logic [LocW-SplitW+BsW-1:0] pl_q;
  logic [LocW-1:0]   base_q;    // row * block size
  logic [LenW-1:0]   done_q;
  logic [LenW-1:0]   rem_len_q;

  logic       out_valid_q;
  out_item_t  out_q;

  logic             accept;
  logic             out_load;
  logic             too_many;
  logic [LenW:0]    span;
  logic [SegLimW-1:0] seg_limit;
  logic [BsW-1:0]   size_full;
  logic             seg_last;
  logic [BsW-1:0]   seg_size;
  logic             node_wrap;

  bss_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  bss_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .req_i   (div_req),
    .rsp_o   (div_rsp)
  );

  assign accept   = in_valid_i & in_ready_o;
  assign out_load = ((state_q == StEmit) || (state_q == StError)) &&
                    (!out_valid_q || out_ready_i);

  // overflow: more than MaxSegments blocks iff off + length > bs * MaxSegments
  assign span      = {{(LenW+1-BsW){1'b0}}, off_q} + {1'b0, len_q};
  assign seg_limit = SegLimW'(cfg.block_size * MaxSegments);
  assign too_many  = span > {{(LenW+1-SegLimW){1'b0}}, seg_limit};

  // current segment
  assign size_full = cfg.block_size - off_q;
  assign seg_last  = {{(LenW-BsW){1'b0}}, size_full} >= rem_len_q;
  assign seg_size  = seg_last ? rem_len_q[BsW-1:0] : size_full;
  assign node_wrap = ({1'b0, node_q} + NcW'(1)) == cfg.node_count;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      StIdle:     if (accept && (in_data_i.length != '0)) state_d = StProduct;
      StProduct:  state_d = StDivLoc;
      StDivLoc:   state_d = StWaitLoc;
      StWaitLoc:  if (div_rsp.done) state_d = StDivNode;
      StDivNode:  state_d = StWaitNode;
      StWaitNode: if (div_rsp.done) state_d = StMulHi;
      StMulHi:    state_d = StMulLo;
      StMulLo:    state_d = StBase;
      StBase:     state_d = too_many ? StError : StEmit;
      StEmit:     if (out_load && seg_last) state_d = StIdle;
      StError:    if (out_load) state_d = StIdle;
      default:    state_d = StIdle;
    endcase
  end

  // sequencer outputs
  always_comb begin
    in_ready_o = 1'b0;
    div_start  = 1'b0;
    div_req    = '0;
    case (state_q)
      StIdle: in_ready_o = 1'b1;
      StDivLoc: begin
        div_start        = 1'b1;
        div_req.rem_init = '0;
        div_req.dividend = loc_q;
        div_req.divisor  = bsnc_q;
        div_req.steps    = StepsLoc;
      end
      StDivNode: begin
        // quotient is below the node count, so only the low NodeW bits remain
        div_start        = 1'b1;
        div_req.rem_init = r1_q >> NodeW;
        div_req.dividend = {r1_q[NodeW-1:0], {(LocW-NodeW){1'b0}}};
        div_req.divisor  = {{(DvsW-BsW){1'b0}}, cfg.block_size};
        div_req.steps    = StepsNode;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (out_load)         out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    case (state_q)
      StIdle: begin
        if (accept) begin
          loc_q     <= in_data_i.location;
          len_q     <= in_data_i.length;
          rem_len_q <= in_data_i.length;
          done_q    <= '0;
        end
      end
      StProduct: bsnc_q <= DvsW'(cfg.block_size * cfg.node_count);
      StWaitLoc: begin
        if (div_rsp.done) begin
          row_q <= div_rsp.quotient;
          r1_q  <= div_rsp.remainder;
        end
      end
      StWaitNode: begin
        if (div_rsp.done) begin
          node_q <= div_rsp.quotient[NodeW-1:0];
          off_q  <= div_rsp.remainder[BsW-1:0];
        end
      end
      StMulHi: ph_q <= SplitW'(row_q[LocW-1:SplitW] * cfg.block_size);
      StMulLo: pl_q <= row_q[SplitW-1:0] * cfg.block_size;
      StBase:  base_q <= {ph_q, {SplitW{1'b0}}} + LocW'(pl_q);
      StEmit: begin
        if (out_load) begin
          done_q    <= done_q + LenW'(seg_size);
          rem_len_q <= rem_len_q - LenW'(seg_size);
          off_q     <= '0;
          if (node_wrap) begin
            node_q <= '0;
            base_q <= base_q + LocW'(cfg.block_size);
          end else begin
            node_q <= node_q + NodeW'(1);
          end
        end
      end
      default: ;
    endcase
  end

  // output register
  always_ff @(posedge clk_i) begin
    if (out_load) begin
      if (state_q == StError) begin
        out_q.owner_node      <= '0;
        out_q.local_address   <= '0;
        out_q.segment_size    <= '0;
        out_q.request_offset  <= '0;
        out_q.last            <= 1'b1;
        out_q.too_many_blocks <= 1'b1;
      end else begin
        out_q.owner_node      <= node_q;
        out_q.local_address   <= base_q + LocW'(off_q);
        out_q.segment_size    <= seg_size;
        out_q.request_offset  <= done_q;
        out_q.last            <= seg_last;
        out_q.too_many_blocks <= 1'b0;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

FILE: verif/block_stripe_segmenter_top_tb.sv
// Self-checking testbench for block_stripe_segmenter_top: random and directed
// requests, behavioural segment prediction, APB register writes between phases.
// Depends on bss_pkg and the RTL under src; reads nothing else.
module block_stripe_segmenter_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import bss_pkg::*;

  localparam int unsigned NumPhases   = 7;
  localparam int unsigned PhaseItems  = 45;
  localparam int unsigned DrainCycles = 120;      // well past the request latency
  localparam int unsigned CycleLimit  = 2000000;
  localparam int unsigned MaxReported = 10;

  logic             clk_i     = 1'b0;
  logic             rst_ni    = 1'b0;
  logic             in_valid  = 1'b0;
  in_item_t         in_data   = '0;
  logic             out_ready = 1'b0;
  logic             psel      = 1'b0;
  logic             penable   = 1'b0;
  logic             pwrite    = 1'b0;
  logic [PaddrW-1:0] paddr    = '0;
  logic [31:0]      pwdata    = '0;

  logic      in_ready_o;
  logic      out_valid_o;
  out_item_t out_data_o;
  logic [31:0] prdata;
  logic      pready;

  // Shadow copies of the two registers, as written over APB
  logic [BsW-1:0] cfg_block_size = BsReset;
  logic [NcW-1:0] cfg_node_count = NcReset;

  in_item_t  pending_reqs[$];   // requests waiting for the driver
  out_item_t expected_segs[$];  // predicted segments, oldest first

  int unsigned error_count = 0;
  int unsigned cycle_count = 0;

  block_stripe_segmenter_top u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready),
    .out_data_o (out_data_o),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------------
  // Segment prediction
  // ---------------------------------------------------------------------------

  // Out-of-range register values are clamped into the legal range
  function automatic bit [63:0] active_block_size();
    if (cfg_block_size == '0) return 64'd1;
    if (cfg_block_size > BsMax) return 64'(BsMax);
    return 64'(cfg_block_size);
  endfunction

  function automatic bit [63:0] active_node_count();
    if (cfg_node_count == '0) return 64'd1;
    if (cfg_node_count > NcMax) return 64'(NcMax);
    return 64'(cfg_node_count);
  endfunction

  // One segment per stripe block touched; block b sits on node b mod nodes,
  // at local byte (b / nodes) * block size. Wide maths so the local address
  // wraps at 40 bits exactly as the hardware truncates it.
  function automatic void split_into_segments(in_item_t req);
    bit [63:0] loc, len, bs, nc, first_blk, last_blk, blk, off, taken, seg_len;
    out_item_t seg;
    loc = req.location;
    len = req.length;
    bs  = active_block_size();
    nc  = active_node_count();
    if (len == 0) return;
    first_blk = loc / bs;
    last_blk  = (loc + len - 1) / bs;
    seg = '0;
    if (last_blk - first_blk + 1 > MaxSegments) begin
      seg.last            = 1'b1;
      seg.too_many_blocks = 1'b1;
      expected_segs.push_back(seg);
      return;
    end
    off   = loc % bs;
    taken = 0;
    for (blk = first_blk; blk <= last_blk; blk++) begin
      seg_len = bs - off;
      if (seg_len > len - taken) seg_len = len - taken;
      seg.owner_node      = NodeW'(blk % nc);
      seg.local_address   = LocW'((blk / nc) * bs + off);
      seg.segment_size    = BsW'(seg_len);
      seg.request_offset  = LenW'(taken);
      seg.last            = (blk == last_blk);
      seg.too_many_blocks = 1'b0;
      expected_segs.push_back(seg);
      taken += seg_len;
      off    = 0;
    end
  endfunction

  function automatic void note_mismatch(string what, out_item_t want, out_item_t got);
    error_count++;
    if (error_count <= MaxReported) begin
      $display("%0t %s", $realtime, what);
      $display("  expected node %0d addr %h size %0d offset %h last %0b err %0b",
               want.owner_node, want.local_address, want.segment_size,
               want.request_offset, want.last, want.too_many_blocks);
      $display("  actual   node %0d addr %h size %0d offset %h last %0b err %0b",
               got.owner_node, got.local_address, got.segment_size,
               got.request_offset, got.last, got.too_many_blocks);
    end
  endfunction

  function automatic void check_segment(out_item_t got);
    out_item_t want;
    if (expected_segs.size() == 0) begin
      note_mismatch("segment with nothing outstanding", '0, got);
      return;
    end
    want = expected_segs.pop_front();
    if (got.owner_node !== want.owner_node || got.local_address !== want.local_address ||
        got.segment_size !== want.segment_size ||
        got.request_offset !== want.request_offset ||
        got.last !== want.last || got.too_many_blocks !== want.too_many_blocks)
      note_mismatch("segment mismatch", want, got);
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  function automatic void queue_req(logic [LocW-1:0] loc, logic [LenW-1:0] len);
    in_item_t req;
    req.location = loc;
    req.length   = len;
    pending_reqs.push_back(req);
  endfunction

  // Mostly well-formed requests spanning 1..67 blocks (straddling the
  // segment limit), plus zero lengths, short ones, huge ones and requests
  // running off the top of the address space.
  function automatic void add_random_reqs(int unsigned count);
    in_item_t    req;
    bit [63:0]   bs, loc64;
    int unsigned pick, span;
    bs = active_block_size();
    for (int unsigned i = 0; i < count; i++) begin
      pick = $urandom_range(0, 9);
      if (pick == 0)
        loc64 = 64'({LocW{1'b1}}) - 64'($urandom_range(0, 32'(4 * bs)));
      else
        loc64 = 64'(LocW'({$urandom, $urandom}));
      if ($urandom_range(0, 3) == 0) loc64 = loc64 - loc64 % bs;  // block aligned
      req.location = LocW'(loc64);
      pick = $urandom_range(0, 19);
      if (pick == 0)
        req.length = '0;
      else if (pick == 1)
        req.length = $urandom;
      else if (pick <= 4)
        req.length = LenW'($urandom_range(1, 32'(bs)));
      else begin
        span = $urandom_range(1, MaxSegments + 2);
        req.length = LenW'(64'(span - 1) * bs + 1 + 64'($urandom_range(0, 32'(bs - 1))));
      end
      pending_reqs.push_back(req);
    end
  endfunction

  // Register write: setup cycle then access cycle; pready is tied high so
  // the write lands on the edge that ends the access cycle.
  task automatic apb_write(input logic reg_sel, input logic [31:0] value);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {reg_sel, 2'b00};
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (reg_sel == RegBlockSize) cfg_block_size = value[BsW-1:0];
    else cfg_node_count = value[NcW-1:0];
  endtask

  // Sampled on the falling edge to stay clear of the clocked blocks. A
  // zero-length request leaves nothing outstanding, hence the extra cycles.
  task automatic wait_drained();
    do @(negedge clk_i);
    while (pending_reqs.size() != 0 || in_valid || expected_segs.size() != 0);
    repeat (DrainCycles) @(negedge clk_i);
  endtask

  // ---------------------------------------------------------------------------
  // Driver: bursts of requests with random gaps; payload held until accepted
  // ---------------------------------------------------------------------------
  int unsigned burst_left = 0;
  int unsigned gap_left   = 0;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid   <= 1'b0;
      in_data    <= '0;
      burst_left <= 0;
      gap_left   <= 0;
    end else if (!in_valid || in_ready_o) begin
      if (gap_left != 0) begin
        gap_left <= gap_left - 1;
        in_valid <= 1'b0;
      end else if (pending_reqs.size() != 0) begin
        in_valid <= 1'b1;
        in_data  <= pending_reqs.pop_front();
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 6);
          gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver: a rotating stall pattern, reloaded every so often; a third of
  // the patterns never stall. Bit 0 forced so every stall is bounded.
  // ---------------------------------------------------------------------------
  logic [15:0] stall_pattern = '1;
  int unsigned pattern_age   = 0;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready     <= 1'b0;
      stall_pattern <= '1;
      pattern_age   <= 0;
    end else if (pattern_age == 0) begin
      pattern_age   <= $urandom_range(40, 160);
      stall_pattern <= ($urandom_range(0, 2) == 0) ? 16'hFFFF : (16'($urandom) | 16'h0001);
      out_ready     <= 1'b1;
    end else begin
      pattern_age   <= pattern_age - 1;
      stall_pattern <= {stall_pattern[0], stall_pattern[15:1]};
      out_ready     <= stall_pattern[0];
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: predict on each accepted request, check each accepted segment
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid && in_ready_o) split_into_segments(in_data);
      if (out_valid_o && out_ready) check_segment(out_data_o);
    end
  end

  // ---------------------------------------------------------------------------
  // Watchdog
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) cycle_count <= cycle_count + 1;

  initial begin
    wait (cycle_count >= CycleLimit);
    $display("simulation failed");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Sequence: directed requests on reset defaults, then phases of register
  // settings (extremes, out-of-range clamps, random) with a full drain
  // mid-phase and before every register write.
  // ---------------------------------------------------------------------------
  initial begin
    static logic [31:0] phase_bs [NumPhases] = '{32'd1, 32'd65536, 32'd0, 32'd131071,
                                                 32'd3, 32'd0, 32'd4096};
    static logic [31:0] phase_nc [NumPhases] = '{32'd1, 32'd64, 32'd0, 32'd127,
                                                 32'd7, 32'd0, 32'd5};
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Block size 8192, one node
    queue_req('0, '0);                                           // zero length
    queue_req('0, 32'd1);
    queue_req('1, 32'd1);                                        // top byte
    queue_req('0, '1);                                           // far too many blocks
    queue_req('1, '1);
    queue_req('0, 32'(MaxSegments * BsReset));                   // exactly at the limit
    queue_req('0, 32'(MaxSegments * BsReset + 1));               // one block over
    queue_req(40'(BsReset - 1), 32'd2);                          // straddles a boundary
    queue_req(40'(BsReset - 1), 32'((MaxSegments - 1) * BsReset + 1));
    queue_req(40'(BsReset - 1), 32'((MaxSegments - 1) * BsReset + 2));
    queue_req(40'hFF_FFFF_FF9C, 32'(3 * BsReset));               // local address wraps
    queue_req(40'hAA_AAAA_AAAA, 32'h0000_5555);
    queue_req(40'h55_5555_5555, 32'h0001_AAAA);
    queue_req(40'd12345, 32'(BsReset));
    queue_req(40'(3 * BsReset), '0);
    add_random_reqs(40);
    wait_drained();

    for (int unsigned p = 0; p < NumPhases; p++) begin
      if (p == 5) begin
        // random raw values, upper bits included
        apb_write(RegBlockSize, $urandom);
        apb_write(RegNodeCount, $urandom);
      end else begin
        apb_write(RegBlockSize, phase_bs[p]);
        apb_write(RegNodeCount, phase_nc[p]);
      end
      add_random_reqs(PhaseItems / 2);
      wait_drained();                      // sender holds off until all is back
      add_random_reqs(PhaseItems - PhaseItems / 2);
      wait_drained();
    end

    if (error_count == 0 && expected_segs.size() == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule
